// ===== hw/rtl/dstl_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstl_pkg - shared types and constants for the DDS serial tuning loader
// Request codes, tuning-word arithmetic constants and the queue entry layout.
// ----------------------------------------------------------------------------
package dstl_pkg;

   localparam int FREQ_BITS   = 26;
   localparam int WORD_BITS   = 32;
   localparam int PHASE_BITS  = 5;
   localparam int CTRL_BITS   = 3;
   localparam int DIVR_BITS   = 21;
   localparam int WORD_SHIFT  = 26;

   localparam logic [FREQ_BITS-1:0] FREQ_MAX_HZ = 26'd40000000;
   // 125 MHz reference: word = freq * 2^26 / 5^9
   localparam logic [DIVR_BITS-1:0] REF_DIVISOR = 21'd1953125;

   // word = floor(freq * RECIP / 2^47), RECIP = ceil(2^73 / 5^9); the rounding
   // error stays below one count for any freq up to 40 MHz
   localparam int RECIP_SHIFT   = 47;
   localparam int RECIP_BITS    = 53;
   localparam int RECIP_LO_BITS = 26;
   localparam int RECIP_HI_BITS = RECIP_BITS - RECIP_LO_BITS;
   localparam int PP_LO_BITS    = FREQ_BITS + RECIP_LO_BITS;
   localparam int PP_HI_BITS    = FREQ_BITS + RECIP_HI_BITS;
   localparam logic [79:0] RECIP_NUM = 80'd1 << (WORD_SHIFT + RECIP_SHIFT);
   localparam logic [RECIP_BITS-1:0] RECIP =
      RECIP_BITS'((RECIP_NUM + 80'(REF_DIVISOR) - 80'd1) / 80'(REF_DIVISOR));

   localparam int SER_BITS    = WORD_BITS + CTRL_BITS + PHASE_BITS;

   localparam logic [5:0] LOAD_LAST_EVT  = 6'd40;
   localparam logic [5:0] LOAD_STOP_SHFT = 6'd39;
   localparam logic [5:0] RST_PULSE_EVT  = 6'd0;
   localparam logic [5:0] RST_CLOCK_EVT  = 6'd1;
   localparam logic [5:0] RST_LAST_EVT   = 6'd2;

   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_RESET = 1'b1;

   typedef struct packed {
      logic                  func;
      logic [WORD_BITS-1:0]  word;
      logic [PHASE_BITS-1:0] phase;
   } entry_type;

   typedef struct packed {
      logic empty;
      logic full;
   } q_status_type;

endpackage

// ===== hw/rtl/dstl_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstl_front - request intake and tuning-word multiplier
// Accepts requests, saturates the frequency, forms the tuning word by a
// reciprocal multiply (MUL, HOLD) and queues it; resets are queued directly.
// ----------------------------------------------------------------------------
module dstl_front import dstl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [FREQ_BITS-1:0]  req_freq_hz,
   input  logic [PHASE_BITS-1:0] req_phase_code,
   input  q_status_type          q_status,
   output logic                  push,
   output entry_type             push_entry
);

   typedef enum logic [2:0] {
      FS_IDLE = 3'b001,
      FS_MUL  = 3'b010,
      FS_HOLD = 3'b100
   } fstate_type;

   fstate_type             state_ff, state_in;
   logic [FREQ_BITS-1:0]   freq_ff, freq_in;
   logic [PHASE_BITS-1:0]  phase_ff, phase_in;
   logic [PP_LO_BITS-1:0]  pp_lo_ff, pp_lo_in;
   logic [PP_HI_BITS-1:0]  pp_hi_ff, pp_hi_in;
   logic [PP_HI_BITS-1:0]  prod_sum;
   logic                   accept;
   logic [FREQ_BITS-1:0]   freq_sat;

   assign busy     = (state_ff != FS_IDLE) || q_status.full;
   assign accept   = start && !busy;
   assign freq_sat = (req_freq_hz > FREQ_MAX_HZ) ? FREQ_MAX_HZ : req_freq_hz;

   // full product shifted down by the low split; the word sits at bit 21
   assign prod_sum = pp_hi_ff + PP_HI_BITS'(pp_lo_ff[PP_LO_BITS-1:RECIP_LO_BITS]);

   always_comb begin
      state_in   = state_ff;
      freq_in    = freq_ff;
      phase_in   = phase_ff;
      pp_lo_in   = pp_lo_ff;
      pp_hi_in   = pp_hi_ff;
      push       = 1'b0;
      push_entry = '{func: FUNC_LOAD,
                     word: prod_sum[RECIP_SHIFT-RECIP_LO_BITS +: WORD_BITS],
                     phase: phase_ff};
      unique case (state_ff)
         FS_IDLE: begin
            if (accept) begin
               if (req_func == FUNC_RESET) begin
                  push       = 1'b1;
                  push_entry = '{func: FUNC_RESET, word: '0, phase: '0};
               end else begin
                  freq_in  = freq_sat;
                  phase_in = req_phase_code;
                  state_in = FS_MUL;
               end
            end
         end
         FS_MUL: begin
            pp_lo_in = PP_LO_BITS'(freq_ff) * PP_LO_BITS'(RECIP[RECIP_LO_BITS-1:0]);
            pp_hi_in = PP_HI_BITS'(freq_ff) * PP_HI_BITS'(RECIP[RECIP_BITS-1:RECIP_LO_BITS]);
            state_in = FS_HOLD;
         end
         FS_HOLD: begin
            if (!q_status.full) begin
               push     = 1'b1;
               state_in = FS_IDLE;
            end
         end
         default: state_in = FS_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= FS_IDLE;
      end else begin
         state_ff <= state_in;
      end
      freq_ff  <= freq_in;
      phase_ff <= phase_in;
      pp_lo_ff <= pp_lo_in;
      pp_hi_ff <= pp_hi_in;
   end

endmodule

// ===== hw/rtl/dstl_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstl_queue - two-entry queue between intake and serialiser
// Holds finished words so each side can stall independently.
// ----------------------------------------------------------------------------
module dstl_queue import dstl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         push,
   input  entry_type    push_entry,
   input  logic         pop,
   output entry_type    head,
   output q_status_type q_status
);

   entry_type  mem_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;

   assign head           = mem_ff[rd_ptr_ff];
   assign q_status.empty = (count_ff == 2'd0);
   assign q_status.full  = (count_ff == 2'd2);

   always_comb begin
      wr_ptr_in = push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop  ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (push) mem_ff[wr_ptr_ff] <= push_entry;
   end

endmodule

// ===== hw/rtl/dstl_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstl_back - pin event serialiser
// Takes queued words and plays out one pin event per cycle: the 40-bit
// serial word with clock pulses and the update strobe, or the reset sequence.
// ----------------------------------------------------------------------------
module dstl_back import dstl_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  q_status_type q_status,
   input  entry_type    head,
   output logic         pop,
   output logic         rsp_strobe,
   output logic         rsp_data_bit,
   output logic         rsp_clock_pulse,
   output logic         rsp_update_pulse,
   output logic         rsp_reset_pulse,
   output logic         rsp_last
);

   logic                 active_ff, active_in;
   logic                 func_ff, func_in;
   logic [SER_BITS-1:0]  sreg_ff, sreg_in;
   logic [5:0]           cnt_ff, cnt_in;
   logic                 last_evt;
   logic                 evt_clk, evt_upd, evt_rst;
   logic                 strobe_ff;
   logic                 data_ff, clk_ff, upd_ff, rst_ff, last_ff;

   assign last_evt = (func_ff == FUNC_RESET) ? (cnt_ff == RST_LAST_EVT)
                                             : (cnt_ff == LOAD_LAST_EVT);
   assign pop = (!active_ff || last_evt) && !q_status.empty;

   always_comb begin
      if (func_ff == FUNC_RESET) begin
         evt_rst = (cnt_ff == RST_PULSE_EVT);
         evt_clk = (cnt_ff == RST_CLOCK_EVT);
         evt_upd = (cnt_ff == RST_LAST_EVT);
      end else begin
         evt_rst = 1'b0;
         evt_clk = (cnt_ff != LOAD_LAST_EVT);
         evt_upd = (cnt_ff == LOAD_LAST_EVT);
      end
   end

   always_comb begin
      active_in = active_ff;
      func_in   = func_ff;
      sreg_in   = sreg_ff;
      cnt_in    = cnt_ff;
      priority if (pop) begin
         active_in = 1'b1;
         func_in   = head.func;
         sreg_in   = {head.phase, {CTRL_BITS{1'b0}}, head.word};
         cnt_in    = '0;
      end else if (active_ff) begin
         if (last_evt) begin
            active_in = 1'b0;
         end else begin
            cnt_in = cnt_ff + 6'd1;
            // data line holds the last phase bit through the update strobe
            if (cnt_ff < LOAD_STOP_SHFT) sreg_in = {1'b0, sreg_ff[SER_BITS-1:1]};
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         strobe_ff <= 1'b0;
      end else begin
         active_ff <= active_in;
         strobe_ff <= active_ff;
      end
      func_ff <= func_in;
      sreg_ff <= sreg_in;
      cnt_ff  <= cnt_in;
      data_ff <= sreg_ff[0];
      clk_ff  <= evt_clk;
      upd_ff  <= evt_upd;
      rst_ff  <= evt_rst;
      last_ff <= last_evt;
   end

   assign rsp_strobe       = strobe_ff;
   assign rsp_data_bit     = data_ff;
   assign rsp_clock_pulse  = clk_ff;
   assign rsp_update_pulse = upd_ff;
   assign rsp_reset_pulse  = rst_ff;
   assign rsp_last         = last_ff;

endmodule

// ===== hw/rtl/dds_serial_tuning_loader_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dds_serial_tuning_loader_unit - DDS serial frequency word loader
// A load request plays out 41 pin events (40 clocked bits, LSB first, then
// the update strobe); a reset request plays out reset, clock and update.
// Events appear on rsp_* one per cycle, each marked by rsp_strobe for one
// cycle, and cannot be held off. A request is taken when start is high and
// busy is low. A load holds busy high while the tuning word is formed by a
// reciprocal multiply in the MUL and HOLD states; a reset request is queued
// in the cycle it is taken. Sustained rate is set by the serialiser emitting
// one event per cycle. A two-word queue lets the next request be taken
// while the current sequence is still playing out; busy stays high while it
// is full. A load passes MUL, HOLD, the queue and the output registers before
// its first event appears; a reset passes only the queue and output registers.
// ----------------------------------------------------------------------------
module dds_serial_tuning_loader_unit import dstl_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic                  req_func,
   input  logic [FREQ_BITS-1:0]  req_freq_hz,
   input  logic [PHASE_BITS-1:0] req_phase_code,
   output logic                  rsp_strobe,
   output logic                  rsp_data_bit,
   output logic                  rsp_clock_pulse,
   output logic                  rsp_update_pulse,
   output logic                  rsp_reset_pulse,
   output logic                  rsp_last
);

   q_status_type q_status;
   logic         push, pop;
   entry_type    push_entry, head;

   dstl_front u_front (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .busy           (busy),
      .req_func       (req_func),
      .req_freq_hz    (req_freq_hz),
      .req_phase_code (req_phase_code),
      .q_status       (q_status),
      .push           (push),
      .push_entry     (push_entry)
   );

   dstl_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .pop        (pop),
      .head       (head),
      .q_status   (q_status)
   );

   dstl_back u_back (
      .clock            (clock),
      .reset            (reset),
      .q_status         (q_status),
      .head             (head),
      .pop              (pop),
      .rsp_strobe       (rsp_strobe),
      .rsp_data_bit     (rsp_data_bit),
      .rsp_clock_pulse  (rsp_clock_pulse),
      .rsp_update_pulse (rsp_update_pulse),
      .rsp_reset_pulse  (rsp_reset_pulse),
      .rsp_last         (rsp_last)
   );

endmodule

// ===== hw/rtl/dstl_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dstl_checker - port-level checks for the DDS serial tuning loader
// Watches the request handshake and the event stream of the top level.
// ----------------------------------------------------------------------------
module dstl_checker (
   input logic clock,
   input logic reset,
   input logic start,
   input logic busy,
   input logic req_func,
   input logic rsp_strobe,
   input logic rsp_data_bit,
   input logic rsp_clock_pulse,
   input logic rsp_update_pulse,
   input logic rsp_reset_pulse,
   input logic rsp_last
);

   // every event is exactly one kind of pin action
   a_one_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $onehot({rsp_clock_pulse, rsp_update_pulse, rsp_reset_pulse}))
      else $error("event is not exactly one pin action");

   // the update strobe closes every sequence and nothing else does
   a_upd_last: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_update_pulse == rsp_last))
      else $error("update strobe and last word disagree");

   // reset strobe is followed at once by a clock pulse with data low
   a_rst_seq: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_reset_pulse |=> rsp_strobe && rsp_clock_pulse && !rsp_data_bit)
      else $error("reset strobe not followed by clock pulse");

   // a load keeps the intake busy while the word is formed
   a_load_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy && !req_func |=> busy)
      else $error("intake free right after a load request");

endmodule

bind dds_serial_tuning_loader_unit dstl_checker u_dstl_checker (
   .clock            (clock),
   .reset            (reset),
   .start            (start),
   .busy             (busy),
   .req_func         (req_func),
   .rsp_strobe       (rsp_strobe),
   .rsp_data_bit     (rsp_data_bit),
   .rsp_clock_pulse  (rsp_clock_pulse),
   .rsp_update_pulse (rsp_update_pulse),
   .rsp_reset_pulse  (rsp_reset_pulse),
   .rsp_last         (rsp_last)
);
